// ===== rtl/core/gjta_pkg.sv =====
package gjta_pkg;

   // field widths
   localparam int FUNC_W = 2;
   localparam int VIDX_W = 2;
   localparam int ANT_W  = 8;
   localparam int IN_W   = 16;
   localparam int PROD_W = 2 * IN_W;
   localparam int DOT_W  = PROD_W + 1;
   localparam int ACC_W  = 48;

   // function codes on the request port
   localparam logic [FUNC_W-1:0] FUNC_ACCUMULATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ_CLEAR = 2'd2;

   // decoded operation
   typedef enum logic [1:0] {
      OP_NONE,
      OP_ACCUMULATE,
      OP_READ,
      OP_READ_CLEAR
   } op_type;

   // classified transaction passed from front to back
   typedef struct packed {
      op_type                   op;
      logic                     valid_a;
      logic                     valid_b;
      logic [VIDX_W-1:0]        vector_index;
      logic [ANT_W-1:0]         antenna_a;
      logic [ANT_W-1:0]         antenna_b;
      logic signed [DOT_W-1:0]  d1;
      logic signed [DOT_W-1:0]  d2;
   } item_type;

   // back-end status seen by the front
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

// ===== rtl/core/gain_jacobian_transpose_accumulate.sv =====
// flow: a request passes the front stage and the queue before the back end serves it
// back end: serves one transaction at a time while the front accepts more, by the
//   read-modify-write of one or two entries through the single accumulator memory
// reset: synchronous; after reset a clearing pass zeroes all NVEC*NANT entries,
//   one per cycle, holding req_full high for the whole pass
module gain_jacobian_transpose_accumulate #(
   parameter int NANT = 256,
   parameter int NVEC = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [gjta_pkg::FUNC_W-1:0]          req_func,
   input  logic [gjta_pkg::VIDX_W-1:0]          req_vector_index,
   input  logic [gjta_pkg::ANT_W-1:0]           req_antenna_a,
   input  logic [gjta_pkg::ANT_W-1:0]           req_antenna_b,
   input  logic signed [gjta_pkg::IN_W-1:0]     req_vis_re,
   input  logic signed [gjta_pkg::IN_W-1:0]     req_vis_im,
   input  logic signed [gjta_pkg::IN_W-1:0]     req_vec_re,
   input  logic signed [gjta_pkg::IN_W-1:0]     req_vec_im,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [gjta_pkg::ACC_W-1:0]    rsp_acc_re,
   output logic signed [gjta_pkg::ACC_W-1:0]    rsp_acc_im,
   output logic                                 rsp_status
);

   logic                        q_push;
   logic                        q_full;
   logic                        q_pop;
   logic                        q_empty;
   gjta_pkg::item_type          q_item_in;
   gjta_pkg::item_type          q_item_out;
   gjta_pkg::back_status_type   back_status;

   // decode, range check and products
   gjta_front #(
      .NANT (NANT),
      .NVEC (NVEC)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_vector_index (req_vector_index),
      .req_antenna_a    (req_antenna_a),
      .req_antenna_b    (req_antenna_b),
      .req_vis_re       (req_vis_re),
      .req_vis_im       (req_vis_im),
      .req_vec_re       (req_vec_re),
      .req_vec_im       (req_vec_im),
      .back_status      (back_status),
      .q_push           (q_push),
      .q_item           (q_item_in),
      .q_full           (q_full)
   );

   // decoupling queue between front and back
   gjta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item_out),
      .empty     (q_empty)
   );

   // accumulator memory and update sequencer
   gjta_back #(
      .NANT (NANT),
      .NVEC (NVEC)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_item      (q_item_out),
      .q_pop       (q_pop),
      .back_status (back_status),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_acc_re  (rsp_acc_re),
      .rsp_acc_im  (rsp_acc_im),
      .rsp_status  (rsp_status)
   );

endmodule

// ===== rtl/core/gjta_front.sv =====
module gjta_front #(
   parameter int NANT = 256,
   parameter int NVEC = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [gjta_pkg::FUNC_W-1:0]            req_func,
   input  logic [gjta_pkg::VIDX_W-1:0]            req_vector_index,
   input  logic [gjta_pkg::ANT_W-1:0]             req_antenna_a,
   input  logic [gjta_pkg::ANT_W-1:0]             req_antenna_b,
   input  logic signed [gjta_pkg::IN_W-1:0]       req_vis_re,
   input  logic signed [gjta_pkg::IN_W-1:0]       req_vis_im,
   input  logic signed [gjta_pkg::IN_W-1:0]       req_vec_re,
   input  logic signed [gjta_pkg::IN_W-1:0]       req_vec_im,
   input  gjta_pkg::back_status_type              back_status,
   output logic                                   q_push,
   output gjta_pkg::item_type                     q_item,
   input  logic                                   q_full
);

   logic                                  accept;
   logic                                  vi_ok;
   logic                                  a_ok;
   logic                                  b_ok;
   gjta_pkg::op_type                      op_in;

   logic                                  s1_valid_ff;
   gjta_pkg::op_type                      s1_op_ff;
   logic                                  s1_valid_a_ff;
   logic                                  s1_valid_b_ff;
   logic [gjta_pkg::VIDX_W-1:0]           s1_vi_ff;
   logic [gjta_pkg::ANT_W-1:0]            s1_ant_a_ff;
   logic [gjta_pkg::ANT_W-1:0]            s1_ant_b_ff;
   logic signed [gjta_pkg::PROD_W-1:0]    s1_p_rr_ff;
   logic signed [gjta_pkg::PROD_W-1:0]    s1_p_ii_ff;
   logic signed [gjta_pkg::PROD_W-1:0]    s1_p_ri_ff;
   logic signed [gjta_pkg::PROD_W-1:0]    s1_p_ir_ff;

   // stall while the stage holds a transaction the queue cannot take, or during clear
   assign req_full = back_status.clearing || (s1_valid_ff && q_full);
   assign accept   = req_push && !req_full;

   // range checks and function decode
   always_comb begin
      vi_ok = int'(req_vector_index) < NVEC;
      a_ok  = int'(req_antenna_a) < NANT;
      b_ok  = int'(req_antenna_b) < NANT;
      unique case (req_func)
         gjta_pkg::FUNC_ACCUMULATE: op_in = gjta_pkg::OP_ACCUMULATE;
         gjta_pkg::FUNC_READ:       op_in = gjta_pkg::OP_READ;
         gjta_pkg::FUNC_READ_CLEAR: op_in = gjta_pkg::OP_READ_CLEAR;
         default:                   op_in = gjta_pkg::OP_NONE;
      endcase
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (q_push) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // stage payload with registered products
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= op_in;
         s1_valid_a_ff <= vi_ok && a_ok;
         s1_valid_b_ff <= vi_ok && b_ok;
         s1_vi_ff      <= req_vector_index;
         s1_ant_a_ff   <= req_antenna_a;
         s1_ant_b_ff   <= req_antenna_b;
         s1_p_rr_ff    <= gjta_pkg::PROD_W'(req_vis_re) * gjta_pkg::PROD_W'(req_vec_re);
         s1_p_ii_ff    <= gjta_pkg::PROD_W'(req_vis_im) * gjta_pkg::PROD_W'(req_vec_im);
         s1_p_ri_ff    <= gjta_pkg::PROD_W'(req_vis_re) * gjta_pkg::PROD_W'(req_vec_im);
         s1_p_ir_ff    <= gjta_pkg::PROD_W'(req_vis_im) * gjta_pkg::PROD_W'(req_vec_re);
      end
   end

   // sums of products and hand-off to the queue
   assign q_push = s1_valid_ff && !q_full;

   always_comb begin
      q_item.op           = s1_op_ff;
      q_item.valid_a      = s1_valid_a_ff;
      q_item.valid_b      = s1_valid_b_ff;
      q_item.vector_index = s1_vi_ff;
      q_item.antenna_a    = s1_ant_a_ff;
      q_item.antenna_b    = s1_ant_b_ff;
      q_item.d1 = gjta_pkg::DOT_W'(s1_p_rr_ff) + gjta_pkg::DOT_W'(s1_p_ii_ff);
      q_item.d2 = gjta_pkg::DOT_W'(s1_p_ri_ff) - gjta_pkg::DOT_W'(s1_p_ir_ff);
   end

endmodule

// ===== rtl/core/gjta_queue.sv =====
module gjta_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gjta_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output gjta_pkg::item_type  pop_item,
   output logic                empty
);

   localparam logic [1:0] COUNT_FULL = 2'd2;

   gjta_pkg::item_type  entry_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;
   logic                push_ok;
   logic                pop_ok;

   assign full     = count_ff == COUNT_FULL;
   assign empty    = count_ff == 2'd0;
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         priority if (push_ok && !pop_ok) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - 2'd1;
         end else begin
            count_ff <= count_ff;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/gjta_back.sv =====
module gjta_back #(
   parameter int NANT = 256,
   parameter int NVEC = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   input  gjta_pkg::item_type                   q_item,
   output logic                                 q_pop,
   output gjta_pkg::back_status_type            back_status,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [gjta_pkg::ACC_W-1:0]    rsp_acc_re,
   output logic signed [gjta_pkg::ACC_W-1:0]    rsp_acc_im,
   output logic                                 rsp_status
);

   localparam int DEPTH  = NVEC * NANT;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ACC_W  = gjta_pkg::ACC_W;
   localparam int DOT_W  = gjta_pkg::DOT_W;
   localparam int WORD_W = 2 * ACC_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE_A,
      ST_UPDATE_B
   } state_type;

   typedef struct packed {
      logic [ACC_W-1:0] value;
      logic             ovf;
   } sat_type;

   // flat entry address, zero when the entry is out of range
   function automatic logic [AW-1:0] entry_addr(
      input logic                          valid,
      input logic [gjta_pkg::VIDX_W-1:0]   vi,
      input logic [gjta_pkg::ANT_W-1:0]    ant
   );
      logic [AW-1:0] addr;
      addr = '0;
      if (valid) begin
         addr = AW'(int'(vi) * NANT + int'(ant));
      end
      return addr;
   endfunction

   // 48-bit saturating add of a 34-bit signed delta
   function automatic sat_type sat_add(
      input logic [ACC_W-1:0]  acc,
      input logic [DOT_W:0]    delta
   );
      logic [ACC_W:0] sum;
      sat_type        res;
      sum = {acc[ACC_W-1], acc} + {{(ACC_W-DOT_W){delta[DOT_W]}}, delta};
      res.ovf = sum[ACC_W] ^ sum[ACC_W-1];
      if (res.ovf) begin
         res.value = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         res.value = sum[ACC_W-1:0];
      end
      return res;
   endfunction

   state_type           state_ff;
   gjta_pkg::item_type  cur_ff;
   logic                same_ff;
   logic                flag_ff;
   logic [WORD_W-1:0]   fwd_ff;
   logic [AW-1:0]       clr_cnt_ff;
   logic                rsp_valid_ff;
   logic [ACC_W-1:0]    rsp_re_ff;
   logic [ACC_W-1:0]    rsp_im_ff;
   logic                rsp_status_ff;
   logic [WORD_W-1:0]   rd_data_ff;
   logic [WORD_W-1:0]   mem_ff [DEPTH];

   logic                out_free;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       addr_a;
   logic [AW-1:0]       addr_b;
   logic [WORD_W-1:0]   base;
   logic [DOT_W:0]      d1_ext;
   logic [DOT_W:0]      d2_ext;
   logic [DOT_W:0]      delta_im;
   sat_type             sat_re;
   sat_type             sat_im;
   logic [WORD_W-1:0]   upd_word;
   logic                we;
   logic [AW-1:0]       waddr;
   logic [WORD_W-1:0]   wdata;

   assign back_status.clearing = state_ff == ST_CLEAR;
   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_acc_re = rsp_re_ff;
   assign rsp_acc_im = rsp_im_ff;
   assign rsp_status = rsp_status_ff;

   // take the next transaction only when the result slot will be free
   assign out_free = !rsp_valid_ff || rsp_pop;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty && out_free;

   // addresses: first entry from the queue head, second from the current transaction
   assign addr_a  = entry_addr(cur_ff.valid_a, cur_ff.vector_index, cur_ff.antenna_a);
   assign addr_b  = entry_addr(cur_ff.valid_b, cur_ff.vector_index, cur_ff.antenna_b);
   assign rd_addr = (state_ff == ST_IDLE)
                    ? entry_addr(q_item.valid_a, q_item.vector_index, q_item.antenna_a)
                    : addr_b;

   // shared saturating update, forwarding the first write when both antennas match
   always_comb begin
      base     = (state_ff == ST_UPDATE_B && same_ff) ? fwd_ff : rd_data_ff;
      d1_ext   = {cur_ff.d1[DOT_W-1], cur_ff.d1};
      d2_ext   = {cur_ff.d2[DOT_W-1], cur_ff.d2};
      delta_im = (state_ff == ST_UPDATE_A) ? ((DOT_W + 1)'(0) - d2_ext) : d2_ext;
      sat_re   = sat_add(base[WORD_W-1:ACC_W], d1_ext);
      sat_im   = sat_add(base[ACC_W-1:0], delta_im);
      upd_word = {sat_re.value, sat_im.value};
   end

   // memory write select
   always_comb begin
      we    = 1'b0;
      waddr = addr_a;
      wdata = upd_word;
      unique case (state_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            waddr = clr_cnt_ff;
            wdata = '0;
         end
         ST_UPDATE_A: begin
            if (cur_ff.op == gjta_pkg::OP_ACCUMULATE) begin
               we = cur_ff.valid_a;
            end else if (cur_ff.op == gjta_pkg::OP_READ_CLEAR) begin
               we    = cur_ff.valid_a;
               wdata = '0;
            end
         end
         ST_UPDATE_B: begin
            we    = cur_ff.valid_b;
            waddr = addr_b;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   // accumulator memory, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (clr_cnt_ff == AW'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (q_pop) begin
                  cur_ff   <= q_item;
                  state_ff <= ST_UPDATE_A;
               end
            end
            ST_UPDATE_A: begin
               unique case (cur_ff.op)
                  gjta_pkg::OP_ACCUMULATE: begin
                     fwd_ff   <= upd_word;
                     flag_ff  <= cur_ff.valid_a && (sat_re.ovf || sat_im.ovf);
                     same_ff  <= cur_ff.valid_a && (cur_ff.antenna_a == cur_ff.antenna_b);
                     state_ff <= ST_UPDATE_B;
                  end
                  gjta_pkg::OP_READ, gjta_pkg::OP_READ_CLEAR: begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_re_ff     <= cur_ff.valid_a ? rd_data_ff[WORD_W-1:ACC_W] : '0;
                     rsp_im_ff     <= cur_ff.valid_a ? rd_data_ff[ACC_W-1:0] : '0;
                     rsp_status_ff <= 1'b0;
                     state_ff      <= ST_IDLE;
                  end
                  default: begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_re_ff     <= '0;
                     rsp_im_ff     <= '0;
                     rsp_status_ff <= 1'b0;
                     state_ff      <= ST_IDLE;
                  end
               endcase
            end
            ST_UPDATE_B: begin
               rsp_valid_ff  <= 1'b1;
               rsp_re_ff     <= '0;
               rsp_im_ff     <= '0;
               rsp_status_ff <= flag_ff || (cur_ff.valid_b && (sat_re.ovf || sat_im.ovf));
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== dv/gain_jacobian_transpose_accumulate_tb.sv =====
module gain_jacobian_transpose_accumulate_tb;

   localparam int NANT = 256;
   localparam int NVEC = 4;
   localparam int CLOCK_PERIOD = 20;
   localparam int RANDOM_ITEMS = 1670;
   localparam logic [gjta_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam longint ACC_MAX_L = (longint'(1) <<< (gjta_pkg::ACC_W - 1)) - 1;
   localparam longint ACC_MIN_L = -(longint'(1) <<< (gjta_pkg::ACC_W - 1));

   // one request transaction as driven on the req_ ports
   typedef struct {
      logic [gjta_pkg::FUNC_W-1:0]       func;
      logic [gjta_pkg::VIDX_W-1:0]       vector_index;
      logic [gjta_pkg::ANT_W-1:0]        antenna_a;
      logic [gjta_pkg::ANT_W-1:0]        antenna_b;
      logic signed [gjta_pkg::IN_W-1:0]  vis_re;
      logic signed [gjta_pkg::IN_W-1:0]  vis_im;
      logic signed [gjta_pkg::IN_W-1:0]  vec_re;
      logic signed [gjta_pkg::IN_W-1:0]  vec_im;
   } gain_request_type;

   // one response transaction as seen on the rsp_ ports
   typedef struct {
      logic signed [gjta_pkg::ACC_W-1:0] acc_re;
      logic signed [gjta_pkg::ACC_W-1:0] acc_im;
      logic                              status;
   } gain_response_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_push = 1'b0;
   logic                              req_full;
   logic [gjta_pkg::FUNC_W-1:0]       req_func = '0;
   logic [gjta_pkg::VIDX_W-1:0]       req_vector_index = '0;
   logic [gjta_pkg::ANT_W-1:0]        req_antenna_a = '0;
   logic [gjta_pkg::ANT_W-1:0]        req_antenna_b = '0;
   logic signed [gjta_pkg::IN_W-1:0]  req_vis_re = '0;
   logic signed [gjta_pkg::IN_W-1:0]  req_vis_im = '0;
   logic signed [gjta_pkg::IN_W-1:0]  req_vec_re = '0;
   logic signed [gjta_pkg::IN_W-1:0]  req_vec_im = '0;
   logic                              rsp_empty;
   logic                              rsp_pop = 1'b0;
   logic signed [gjta_pkg::ACC_W-1:0] rsp_acc_re;
   logic signed [gjta_pkg::ACC_W-1:0] rsp_acc_im;
   logic                              rsp_status;

   // predicted accumulator store and the responses still to come
   logic signed [gjta_pkg::ACC_W-1:0] gain_sum_re [NVEC][NANT];
   logic signed [gjta_pkg::ACC_W-1:0] gain_sum_im [NVEC][NANT];
   gain_response_type                 pending_responses [$];

   int  error_count = 0;
   int  requests_sent = 0;
   int  responses_checked = 0;
   int  saturating_requests = 0;
   int  input_stall_cycles = 0;
   bit  sender_idle = 1'b1;
   bit  receiver_idle = 1'b1;
   int  receiver_hold_cycles = 0;

   gain_jacobian_transpose_accumulate #(
      .NANT(NANT),
      .NVEC(NVEC)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_vector_index (req_vector_index),
      .req_antenna_a    (req_antenna_a),
      .req_antenna_b    (req_antenna_b),
      .req_vis_re       (req_vis_re),
      .req_vis_im       (req_vis_im),
      .req_vec_re       (req_vec_re),
      .req_vec_im       (req_vec_im),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_acc_re       (rsp_acc_re),
      .rsp_acc_im       (rsp_acc_im),
      .rsp_status       (rsp_status)
   );

   // clock
   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #80_000_000;
      $display("[gain_jacobian_transpose_accumulate] ERROR");
      $finish;
   end

   // saturating 48-bit add, sets hit on clamp
   function automatic logic signed [gjta_pkg::ACC_W-1:0] saturate_add(
      input logic signed [gjta_pkg::ACC_W-1:0] acc,
      input longint                            delta,
      inout bit                                hit
   );
      longint sum;
      sum = longint'(acc) + delta;
      if (sum > ACC_MAX_L) begin
         sum = ACC_MAX_L;
         hit = 1'b1;
      end else if (sum < ACC_MIN_L) begin
         sum = ACC_MIN_L;
         hit = 1'b1;
      end
      return sum[gjta_pkg::ACC_W-1:0];
   endfunction

   // apply one request to the predicted store and return its response
   function automatic gain_response_type predict_gain_update(input gain_request_type rq);
      gain_response_type rsp;
      longint            d1;
      longint            d2;
      bit                hit;
      hit = 1'b0;
      rsp.acc_re = '0;
      rsp.acc_im = '0;
      case (rq.func)
         gjta_pkg::FUNC_ACCUMULATE: begin
            if (rq.vector_index < NVEC) begin
               d1 = longint'(rq.vis_re) * longint'(rq.vec_re)
                  + longint'(rq.vis_im) * longint'(rq.vec_im);
               d2 = longint'(rq.vis_re) * longint'(rq.vec_im)
                  - longint'(rq.vis_im) * longint'(rq.vec_re);
               if (rq.antenna_a < NANT) begin
                  gain_sum_re[rq.vector_index][rq.antenna_a] =
                     saturate_add(gain_sum_re[rq.vector_index][rq.antenna_a], d1, hit);
                  gain_sum_im[rq.vector_index][rq.antenna_a] =
                     saturate_add(gain_sum_im[rq.vector_index][rq.antenna_a], -d2, hit);
               end
               if (rq.antenna_b < NANT) begin
                  gain_sum_re[rq.vector_index][rq.antenna_b] =
                     saturate_add(gain_sum_re[rq.vector_index][rq.antenna_b], d1, hit);
                  gain_sum_im[rq.vector_index][rq.antenna_b] =
                     saturate_add(gain_sum_im[rq.vector_index][rq.antenna_b], d2, hit);
               end
            end
         end
         gjta_pkg::FUNC_READ, gjta_pkg::FUNC_READ_CLEAR: begin
            if (rq.vector_index < NVEC && rq.antenna_a < NANT) begin
               rsp.acc_re = gain_sum_re[rq.vector_index][rq.antenna_a];
               rsp.acc_im = gain_sum_im[rq.vector_index][rq.antenna_a];
               if (rq.func == gjta_pkg::FUNC_READ_CLEAR) begin
                  gain_sum_re[rq.vector_index][rq.antenna_a] = '0;
                  gain_sum_im[rq.vector_index][rq.antenna_a] = '0;
               end
            end
         end
         default: ;
      endcase
      rsp.status = hit;
      return rsp;
   endfunction

   function automatic gain_request_type make_request(
      input logic [gjta_pkg::FUNC_W-1:0]      func,
      input logic [gjta_pkg::VIDX_W-1:0]      vector_index,
      input logic [gjta_pkg::ANT_W-1:0]       antenna_a,
      input logic [gjta_pkg::ANT_W-1:0]       antenna_b,
      input logic signed [gjta_pkg::IN_W-1:0] vis_re,
      input logic signed [gjta_pkg::IN_W-1:0] vis_im,
      input logic signed [gjta_pkg::IN_W-1:0] vec_re,
      input logic signed [gjta_pkg::IN_W-1:0] vec_im
   );
      gain_request_type rq;
      rq.func = func;
      rq.vector_index = vector_index;
      rq.antenna_a = antenna_a;
      rq.antenna_b = antenna_b;
      rq.vis_re = vis_re;
      rq.vis_im = vis_im;
      rq.vec_re = vec_re;
      rq.vec_im = vec_im;
      return rq;
   endfunction

   // sample values biased toward the extremes
   function automatic logic signed [gjta_pkg::IN_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return '1;
         default: return gjta_pkg::IN_W'($urandom());
      endcase
   endfunction

   // antennas half the time from a small set at both ends so reads hit live entries
   function automatic logic [gjta_pkg::ANT_W-1:0] pick_antenna();
      case ($urandom_range(0, 3))
         0: return gjta_pkg::ANT_W'($urandom_range(0, 3));
         1: return gjta_pkg::ANT_W'(NANT - 1 - $urandom_range(0, 3));
         default: return gjta_pkg::ANT_W'($urandom());
      endcase
   endfunction

   function automatic gain_request_type random_request();
      gain_request_type rq;
      int               pick;
      pick = $urandom_range(0, 19);
      if (pick < 11) rq.func = gjta_pkg::FUNC_ACCUMULATE;
      else if (pick < 15) rq.func = gjta_pkg::FUNC_READ;
      else if (pick < 19) rq.func = gjta_pkg::FUNC_READ_CLEAR;
      else rq.func = FUNC_UNUSED;
      rq.vector_index = gjta_pkg::VIDX_W'($urandom());
      rq.antenna_a = pick_antenna();
      rq.antenna_b = ($urandom_range(0, 7) == 0) ? rq.antenna_a : pick_antenna();
      rq.vis_re = pick_sample();
      rq.vis_im = pick_sample();
      rq.vec_re = pick_sample();
      rq.vec_im = pick_sample();
      return rq;
   endfunction

   // drive one transaction, wait for it to be taken, record its prediction
   task automatic send_gain_request(input gain_request_type rq);
      int                gap;
      gain_response_type rsp;
      gap = sender_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_func <= rq.func;
      req_vector_index <= rq.vector_index;
      req_antenna_a <= rq.antenna_a;
      req_antenna_b <= rq.antenna_b;
      req_vis_re <= rq.vis_re;
      req_vis_im <= rq.vis_im;
      req_vec_re <= rq.vec_re;
      req_vec_im <= rq.vec_im;
      do begin
         @(posedge clock);
         if (req_full) input_stall_cycles++;
      end while (req_full);
      rsp = predict_gain_update(rq);
      if (rsp.status) saturating_requests++;
      pending_responses.push_back(rsp);
      requests_sent++;
   endtask

   task automatic wait_drain();
      req_push <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // store must read back as zero after the reset clearing pass
   task automatic test_reset_state();
      send_gain_request(make_request(gjta_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ_CLEAR, 3, 255, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ, 2, 128, 255, -1, -1, -1, -1));
      wait_drain();
   endtask

   // field extremes, every function, equal antennas, unused code
   task automatic test_directed_corners();
      send_gain_request(make_request(FUNC_UNUSED, 3, 255, 255, -1, -1, -1, -1));
      send_gain_request(make_request(gjta_pkg::FUNC_ACCUMULATE, 0, 0, 255,
                                     16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff));
      send_gain_request(make_request(gjta_pkg::FUNC_ACCUMULATE, 0, 0, 255,
                                     16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000));
      send_gain_request(make_request(gjta_pkg::FUNC_ACCUMULATE, 3, 128, 128,
                                     16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
      send_gain_request(make_request(gjta_pkg::FUNC_ACCUMULATE, 3, 128, 128,
                                     3, -5, 7, 11));
      send_gain_request(make_request(gjta_pkg::FUNC_ACCUMULATE, 1, 85, 170,
                                     0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_ACCUMULATE, 2, 170, 85,
                                     -1, 1, 1, -1));
      send_gain_request(make_request(FUNC_UNUSED, 0, 0, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ, 0, 255, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ, 2, 170, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ, 2, 85, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ_CLEAR, 3, 128, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ, 3, 128, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
      send_gain_request(make_request(gjta_pkg::FUNC_READ_CLEAR, 0, 255, 0, 0, 0, 0, 0));
      wait_drain();
   endtask

   // receiver holds off while the sender keeps pushing, so the block backs up
   task automatic test_backpressure();
      sender_idle = 1'b0;
      receiver_hold_cycles = 400;
      repeat (64) send_gain_request(random_request());
      wait_drain();
      sender_idle = 1'b1;
   endtask

   // random traffic in stretches with and without idling on either side
   task automatic test_random_traffic();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            sender_idle = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
         end
         send_gain_request(random_request());
      end
      wait_drain();
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
   endtask

   // response side: random stalls, a long hold on request, check each transaction
   initial begin : response_checker
      int                stall;
      gain_response_type want;
      do @(posedge clock); while (reset);
      forever begin
         if (receiver_hold_cycles > 0) begin
            stall = receiver_hold_cycles;
            receiver_hold_cycles = 0;
         end else begin
            stall = receiver_idle ? $urandom_range(0, 11) : 0;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (pending_responses.size() == 0) begin
            $error("unexpected response: acc_re %0d acc_im %0d status %0d",
                   rsp_acc_re, rsp_acc_im, rsp_status);
            error_count++;
         end else begin
            want = pending_responses.pop_front();
            responses_checked++;
            if (rsp_acc_re !== want.acc_re) begin
               $error("acc_re mismatch: expected %0d, actual %0d", want.acc_re, rsp_acc_re);
               error_count++;
            end
            if (rsp_acc_im !== want.acc_im) begin
               $error("acc_im mismatch: expected %0d, actual %0d", want.acc_im, rsp_acc_im);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // reset, tests in turn, final report
   initial begin
      for (int v = 0; v < NVEC; v++) begin
         for (int a = 0; a < NANT; a++) begin
            gain_sum_re[v][a] = '0;
            gain_sum_im[v][a] = '0;
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_corners();
      test_backpressure();
      test_random_traffic();

      // let any stray response show up
      wait_drain();
      repeat (20) @(posedge clock);
      if (pending_responses.size() != 0) begin
         $error("%0d responses never arrived", pending_responses.size());
         error_count++;
      end

      $display("sent %0d transactions, checked %0d responses, %0d with saturation",
               requests_sent, responses_checked, saturating_requests);
      $display("input held off for %0d cycles by a full block or the clearing pass",
               input_stall_cycles);
      if (error_count == 0) begin
         $display("[gain_jacobian_transpose_accumulate] OK");
      end else begin
         $display("[gain_jacobian_transpose_accumulate] ERROR");
      end
      $finish;
   end

endmodule
